// ===== hw/rtl/snorm_pkg.sv =====
package snorm_pkg;

  // sample and register widths
  localparam int unsigned SampleBits = 16;
  localparam int unsigned RadixW     = SampleBits + 1;
  localparam int unsigned OutW       = 8;
  localparam int unsigned NumCh      = 3;
  localparam int unsigned DivSteps   = OutW;
  localparam int unsigned QFrac      = 16;
  localparam int unsigned AccW       = 27;
  localparam int unsigned CfgIdxW    = 2;

  // request to result latency: entry stage, divider steps, two convert stages
  localparam int unsigned Latency    = 1 + DivSteps + 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegFormatMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInputRadix = 2'd1;

  // format modes
  localparam logic [1:0] ModeLuma   = 2'd0;
  localparam logic [1:0] ModeYcc    = 2'd1;
  localparam logic [1:0] ModeRgb    = 2'd2;
  localparam logic [1:0] ModeRgbAlt = 2'd3;

  localparam logic [1:0]        FormatModeRst = ModeYcc;
  localparam logic [RadixW-1:0] InputRadixRst = RadixW'(256);

  // q16 bt.601 full-range coefficients
  localparam logic signed [AccW-1:0] CoefCrR = 27'sd91881;
  localparam logic signed [AccW-1:0] CoefCbG = 27'sd22544;
  localparam logic signed [AccW-1:0] CoefCrG = 27'sd46793;
  localparam logic signed [AccW-1:0] CoefCbB = 27'sd116130;
  localparam logic signed [OutW:0]   ChromaMid = 9'sd128;
  localparam logic [OutW-1:0]        Max8 = 8'hFF;

  typedef struct packed {
    logic [SampleBits-1:0] ch0_in;
    logic [SampleBits-1:0] ch1_in;
    logic [SampleBits-1:0] ch2_in;
  } pix_in_t;

  typedef struct packed {
    logic [OutW-1:0] red_out;
    logic [OutW-1:0] green_out;
    logic [OutW-1:0] blue_out;
  } pix_out_t;

  // floor of q16 sum, clipped to 0..255
  function automatic logic [OutW-1:0] clip_q16(input logic signed [AccW-1:0] acc);
    logic [OutW-1:0] res;
    if (acc[AccW-1]) begin
      res = '0;
    end else if (|acc[AccW-2:QFrac+OutW]) begin
      res = Max8;
    end else begin
      res = acc[QFrac+OutW-1:QFrac];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/snorm_norm.sv =====
module snorm_norm (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  input  snorm_pkg::pix_in_t                          pixel_i,
  input  logic [snorm_pkg::RadixW-1:0]                radix_i,
  output logic                                        valid_o,
  output logic [snorm_pkg::NumCh-1:0][snorm_pkg::OutW-1:0] samp_o
);
  import snorm_pkg::*;

  logic [SampleBits-1:0] samp_in [NumCh];

  logic              valid_q [DivSteps+1];
  logic [RadixW-1:0] rem_q   [DivSteps+1][NumCh];
  logic [OutW-1:0]   quo_q   [DivSteps+1][NumCh];
  logic              sat_q   [DivSteps+1][NumCh];

  logic [RadixW-1:0] rem_d [DivSteps][NumCh];
  logic [OutW-1:0]   quo_d [DivSteps][NumCh];

  assign samp_in[0] = pixel_i.ch0_in;
  assign samp_in[1] = pixel_i.ch1_in;
  assign samp_in[2] = pixel_i.ch2_in;

  // one restoring division step per stage, remainder stays below the radix for samples below it
  always_comb begin
    logic [RadixW:0]   shl;
    logic [RadixW+1:0] diff;
    for (int s = 0; s < DivSteps; s++) begin
      for (int c = 0; c < NumCh; c++) begin
        shl  = {rem_q[s][c], 1'b0};
        diff = {1'b0, shl} - {2'b00, radix_i};
        rem_d[s][c] = diff[RadixW+1] ? shl[RadixW-1:0] : diff[RadixW-1:0];
        quo_d[s][c] = {quo_q[s][c][OutW-2:0], ~diff[RadixW+1]};
      end
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= DivSteps; s++) valid_q[s] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
      for (int s = 0; s < DivSteps; s++) valid_q[s+1] <= valid_q[s];
    end
  end

  // entry stage: sample below radix gives a quotient under 256, else saturate
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NumCh; c++) begin
      rem_q[0][c] <= {1'b0, samp_in[c]};
      quo_q[0][c] <= '0;
      sat_q[0][c] <= (radix_i == '0) || ({1'b0, samp_in[c]} >= radix_i);
    end
    for (int s = 0; s < DivSteps; s++) begin
      for (int c = 0; c < NumCh; c++) begin
        rem_q[s+1][c] <= rem_d[s][c];
        quo_q[s+1][c] <= quo_d[s][c];
        sat_q[s+1][c] <= sat_q[s][c];
      end
    end
  end

  assign valid_o = valid_q[DivSteps];

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      samp_o[c] = sat_q[DivSteps][c] ? Max8 : quo_q[DivSteps][c];
    end
  end

endmodule

// ===== hw/rtl/snorm_conv.sv =====
module snorm_conv (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  input  logic [snorm_pkg::NumCh-1:0][snorm_pkg::OutW-1:0] samp_i,
  input  logic [1:0]                                       mode_i,
  output logic                                             valid_o,
  output snorm_pkg::pix_out_t                              pixel_o
);
  import snorm_pkg::*;

  logic                  pass;
  logic                  luma_only;
  logic signed [OutW:0]  cb_s;
  logic signed [OutW:0]  cr_s;

  logic                  v1_q, v2_q;
  logic                  pass_q;
  logic [OutW-1:0]       a_q, b_q, c_q;
  logic signed [AccW-1:0] t_r_q, t_gb_q, t_gr_q, t_b_q;

  logic signed [AccW-1:0] y_acc;
  logic signed [AccW-1:0] sum_r, sum_g, sum_b;
  pix_out_t              pix_d;
  pix_out_t              pix_q;

  // chroma offsets, forced to zero (chroma at mid-scale) in luma-only mode
  assign pass      = (mode_i == ModeRgb) || (mode_i == ModeRgbAlt);
  assign luma_only = (mode_i == ModeLuma);
  assign cb_s = luma_only ? '0 : $signed({1'b0, samp_i[1]}) - ChromaMid;
  assign cr_s = luma_only ? '0 : $signed({1'b0, samp_i[2]}) - ChromaMid;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // stage one: coefficient products
  always_ff @(posedge clk_i) begin
    pass_q <= pass;
    a_q    <= samp_i[0];
    b_q    <= samp_i[1];
    c_q    <= samp_i[2];
    t_r_q  <= CoefCrR * AccW'(cr_s);
    t_gb_q <= CoefCbG * AccW'(cb_s);
    t_gr_q <= CoefCrG * AccW'(cr_s);
    t_b_q  <= CoefCbB * AccW'(cb_s);
  end

  // stage two: sums, floor and clip, or pass-through in the rgb modes
  assign y_acc = $signed({{(AccW-OutW-QFrac){1'b0}}, a_q, {QFrac{1'b0}}});
  assign sum_r = y_acc + t_r_q;
  assign sum_g = y_acc - t_gb_q - t_gr_q;
  assign sum_b = y_acc + t_b_q;

  always_comb begin
    if (pass_q) begin
      pix_d.red_out   = a_q;
      pix_d.green_out = b_q;
      pix_d.blue_out  = c_q;
    end else begin
      pix_d.red_out   = clip_q16(sum_r);
      pix_d.green_out = clip_q16(sum_g);
      pix_d.blue_out  = clip_q16(sum_b);
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign valid_o = v2_q;
  assign pixel_o = pix_q;

endmodule

// ===== hw/rtl/sample_normalize_ycbcr_to_rgb.sv =====
// pixel normalizer and full-range bt.601 ycbcr to rgb converter
//
// request channel: raise start with pixel_i (three samples) for one cycle; the
// request is taken at a rising edge where start is high and busy is low. busy
// stays low, so a new pixel may be issued in every cycle.
// result channel: result_o is shown for exactly one cycle with result_valid_o
// high; it is taken once the request has passed the entry stage, the eight
// divider stages, the product stage and the sum and clip stage. one pixel per
// clock sustained; most stages belong to the eight-step restoring divider that
// normalizes each sample by input_radix, one quotient bit per stage.
// config channel: cfg_valid_i with cfg_index_i and cfg_data_i, always ready.
// index 0 is format_mode, index 1 is input_radix; other indexes are dropped.
// write registers only while no request is in flight.
// reset: format_mode returns to ycbcr, input_radix to 256, and all pipeline
// valid bits clear so no result appears until new requests arrive.
// the receiver cannot stall; results are never held back.
module sample_normalize_ycbcr_to_rgb (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  snorm_pkg::pix_in_t                pixel_i,
  output logic                              result_valid_o,
  output snorm_pkg::pix_out_t               result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [snorm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [snorm_pkg::RadixW-1:0]      cfg_data_i
);
  import snorm_pkg::*;

  logic [1:0]        format_mode_q, format_mode_d;
  logic [RadixW-1:0] input_radix_q, input_radix_d;
  logic              req;
  logic              norm_valid;
  logic [NumCh-1:0][OutW-1:0] norm_samp;

  // fully pipelined, a request is taken every cycle
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign req         = start && !busy;

  // configuration registers
  always_comb begin
    format_mode_d = format_mode_q;
    input_radix_d = input_radix_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegFormatMode: format_mode_d = cfg_data_i[1:0];
        RegInputRadix: input_radix_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_mode_q <= FormatModeRst;
      input_radix_q <= InputRadixRst;
    end else begin
      format_mode_q <= format_mode_d;
      input_radix_q <= input_radix_d;
    end
  end

  // sample normalization
  snorm_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req),
    .pixel_i (pixel_i),
    .radix_i (input_radix_q),
    .valid_o (norm_valid),
    .samp_o  (norm_samp)
  );

  // color conversion
  snorm_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (norm_valid),
    .samp_i  (norm_samp),
    .mode_i  (format_mode_q),
    .valid_o (result_valid_o),
    .pixel_o (result_o)
  );

endmodule

// ===== hw/rtl/snorm_checker.sv =====
module snorm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);
  import snorm_pkg::*;

  // every request yields a result after the fixed latency
  a_req_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency result_valid_o)
    else $error("request without result at fixed latency");

  // no result without a matching request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##Latency !result_valid_o)
    else $error("result without matching request");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !result_valid_o)
    else $error("result right after reset");

endmodule

bind sample_normalize_ycbcr_to_rgb snorm_checker u_snorm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o)
);
